// ===== design/loct_pkg.sv =====
// Shared types and constants for the LRU object cache tag store.
`default_nettype none

package loct_pkg;

  localparam int unsigned KEY_IN_W      = 32;
  localparam int unsigned SIZE_W        = 17;
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned SLOT_W        = 4;
  localparam logic [SIZE_W-1:0] MAX_OBJ_RESET = SIZE_W'(102400);

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ===== design/loct_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module loct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/lru_object_cache_tags.sv =====
// Top level of the fully associative LRU object cache tag store.
//
// Each transfer on the input channel is a lookup or an insert of a hashed key. The block
// scans its tag RAM one entry per cycle through a single read port, and the result of a
// lookup or insert is loaded into the output register when the item is done; an insert at
// or above the configured size limit skips the scan and goes straight to delivery. The
// input stalls while an item is at work and takes the next item in the cycle after a
// result is loaded. A finished item waits in its last state while the output register
// holds a stalled result, and a loaded result waits in the output register while the
// next item is taken.
// A hit restamps the entry with the incremented use clock; an insert fills the lowest
// empty slot or evicts the lowest-indexed entry with the smallest stamp. No clearing pass
// is needed after reset.
`default_nettype none

module lru_object_cache_tags #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [loct_pkg::SIZE_W-1:0]    cfg_data_i,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           mode_i,
  input  wire logic [loct_pkg::KEY_IN_W-1:0]  key_i,
  input  wire logic [loct_pkg::SIZE_W-1:0]    obj_size_i,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                hit_o,
  output logic [loct_pkg::SLOT_W-1:0]         slot_o,
  output logic [loct_pkg::SIZE_W-1:0]         stored_size_o,
  output logic                                inserted_o,
  output logic                                evicted_o
);

  import loct_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned KW = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
  localparam int unsigned WW = KW + SIZE_W + STAMP_W;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_e              state_q, state_d;
  logic [SIZE_W-1:0]   max_q;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [STAMP_W-1:0]  clock_q, clock_d;
  logic                mode_q, mode_d;
  logic [KW-1:0]       key_q, key_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [IW-1:0]       cmp_q, cmp_d;
  logic                issuing_q, issuing_d;
  logic                pend_q, pend_d;
  logic [IW-1:0]       slot_q, slot_d;
  logic [IW-1:0]       victim_q, victim_d;
  logic [STAMP_W-1:0]  best_q, best_d;
  logic                hit_q, hit_d;
  logic                ins_q, ins_d;
  logic                evict_q, evict_d;

  logic                out_valid_q;
  logic                out_hit_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [SIZE_W-1:0]   out_size_q;
  logic                out_ins_q;
  logic                out_evict_q;

  logic                ram_we;
  logic [WW-1:0]       ram_wdata;
  logic [WW-1:0]       ram_rdata;
  logic [KW-1:0]       rd_key;
  logic [SIZE_W-1:0]   rd_size;
  logic [STAMP_W-1:0]  rd_stamp;
  logic [STAMP_W-1:0]  clock_inc;
  logic                older;
  logic                out_free;
  logic [IW+SLOT_W-1:0] slot_ext;

  assign rd_key    = ram_rdata[WW-1 -: KW];
  assign rd_size   = ram_rdata[STAMP_W +: SIZE_W];
  assign rd_stamp  = ram_rdata[STAMP_W-1:0];
  assign clock_inc = clock_q + STAMP_W'(1);
  assign ram_wdata = {key_q, size_q, clock_inc};
  assign older     = (cmp_q == '0) || (rd_stamp < best_q);
  assign out_free  = !out_valid_q || !out_stall;
  assign slot_ext  = {{SLOT_W{1'b0}}, slot_q};

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != S_IDLE);

  loct_ram #(
    .WIDTH(WW),
    .DEPTH(ENTRIES)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    clock_d   = clock_q;
    mode_d    = mode_q;
    key_d     = key_q;
    size_d    = size_q;
    idx_d     = idx_q;
    cmp_d     = cmp_q;
    issuing_d = issuing_q;
    pend_d    = 1'b0;
    slot_d    = slot_q;
    victim_d  = victim_q;
    best_d    = best_q;
    hit_d     = hit_q;
    ins_d     = ins_q;
    evict_d   = evict_q;
    ram_we    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid) begin
          mode_d    = mode_i;
          key_d     = key_i[KW-1:0];
          size_d    = obj_size_i;
          slot_d    = '0;
          hit_d     = 1'b0;
          ins_d     = 1'b0;
          evict_d   = 1'b0;
          idx_d     = '0;
          issuing_d = 1'b1;
          if ((mode_i == MODE_INSERT) && (obj_size_i >= max_q)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issuing_q) begin
          pend_d = 1'b1;
          cmp_d  = idx_q;
          if (idx_q == LAST) begin
            issuing_d = 1'b0;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
        if (pend_q) begin
          if (mode_q == MODE_LOOKUP) begin
            if (valid_q[cmp_q] && (rd_key == key_q)) begin
              hit_d     = 1'b1;
              slot_d    = cmp_q;
              size_d    = rd_size;
              issuing_d = 1'b0;
              state_d   = S_WRITE;
            end else if (cmp_q == LAST) begin
              issuing_d = 1'b0;
              state_d   = S_DONE;
            end
          end else begin
            if (!valid_q[cmp_q]) begin
              slot_d    = cmp_q;
              ins_d     = 1'b1;
              issuing_d = 1'b0;
              state_d   = S_WRITE;
            end else begin
              if (older) begin
                best_d   = rd_stamp;
                victim_d = cmp_q;
              end
              if (cmp_q == LAST) begin
                slot_d    = older ? cmp_q : victim_q;
                ins_d     = 1'b1;
                evict_d   = 1'b1;
                issuing_d = 1'b0;
                state_d   = S_WRITE;
              end
            end
          end
        end
      end
      S_WRITE: begin
        ram_we           = 1'b1;
        clock_d          = clock_inc;
        valid_d[slot_q]  = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_q       <= MAX_OBJ_RESET;
      valid_q     <= '0;
      clock_q     <= '0;
      issuing_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      clock_q   <= clock_d;
      issuing_q <= issuing_d;
      pend_q    <= pend_d;
      if (cfg_valid && cfg_ready) begin
        max_q <= cfg_data_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    key_q    <= key_d;
    size_q   <= size_d;
    idx_q    <= idx_d;
    cmp_q    <= cmp_d;
    slot_q   <= slot_d;
    victim_q <= victim_d;
    best_q   <= best_d;
    hit_q    <= hit_d;
    ins_q    <= ins_d;
    evict_q  <= evict_d;
    if (state_q == S_DONE && out_free) begin
      out_hit_q   <= hit_q;
      out_slot_q  <= slot_ext[SLOT_W-1:0];
      out_size_q  <= hit_q ? size_q : '0;
      out_ins_q   <= ins_q;
      out_evict_q <= evict_q;
    end
  end

  assign out_valid     = out_valid_q;
  assign hit_o         = out_hit_q;
  assign slot_o        = out_slot_q;
  assign stored_size_o = out_size_q;
  assign inserted_o    = out_ins_q;
  assign evicted_o     = out_evict_q;

  a_write_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> state_q == S_DONE)
    else $error("Tag RAM write was not followed by result delivery.");

  a_clock_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clock_q != $past(clock_q) |-> $past(state_q) == S_WRITE)
    else $error("Use clock moved outside a tag write.");

  a_hit_excludes_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(hit_o && inserted_o))
    else $error("Result reports both a hit and an insert.");

  a_evict_needs_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && evicted_o |-> inserted_o)
    else $error("Eviction reported without an insert.");

endmodule

`default_nettype wire
